@@ rtl/cofs_pkg.sv @@
package cofs_pkg;

    // sizing
    localparam int NUM_PEERS  = 64;
    localparam int TIME_BITS  = 48;
    localparam int PEER_BITS  = 6;
    localparam int PEER_IDX_W = $clog2(NUM_PEERS);
    localparam int DIFF_W     = TIME_BITS + 1;
    localparam int LAT_W      = TIME_BITS + 2;
    localparam int CNT_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // stream packing
    localparam int S_FIELDS_W = PEER_BITS + 2 * TIME_BITS;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = TIME_BITS + DIFF_W + LAT_W + CNT_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // request kinds
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_STAMP = 2'd1;
    localparam logic [1:0] REQ_STOP  = 2'd2;
    localparam logic [1:0] REQ_RSVD  = 2'd3;

    // result actions
    localparam logic [1:0] ACT_SEND = 2'd0;
    localparam logic [1:0] ACT_STOP = 2'd1;
    localparam logic [1:0] ACT_DONE = 2'd2;
    localparam logic [1:0] ACT_IGN  = 2'd3;

    // run phase codes
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_FIRST = 2'd1;
    localparam logic [1:0] PH_RUN   = 2'd2;

    // roles
    localparam logic ROLE_INIT = 1'b0;
    localparam logic ROLE_RESP = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX  = 2'd2;

    typedef logic [TIME_BITS-1:0]        time_t;
    typedef logic signed [DIFF_W-1:0]    diff_t;
    typedef logic signed [LAT_W-1:0]     lat_t;
    typedef logic [CNT_W-1:0]            cnt_t;
    typedef logic [PEER_IDX_W-1:0]       peer_idx_t;

    typedef struct packed {
        logic [1:0]           req_type;
        logic [PEER_BITS-1:0] peer;
        time_t                capture_time;
        time_t                remote_time;
    } item_t;

    typedef struct packed {
        logic role;
        cnt_t min_exchanges;
        cnt_t max_exchanges;
    } cfg_t;

    typedef struct packed {
        logic [1:0] action;
        time_t      send_time;
        diff_t      offset;
        lat_t       latency_bound;
        cnt_t       exchanges;
    } result_t;

    typedef struct packed {
        logic      en;
        peer_idx_t addr;
        lat_t      data;
    } lat_wr_t;

endpackage

@@ rtl/cofs_lat_store.sv @@
module cofs_lat_store (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                rd_en,
    input  cofs_pkg::peer_idx_t rd_peer,
    input  cofs_pkg::peer_idx_t chk_peer,
    input  cofs_pkg::lat_wr_t   lat_wr,
    output logic                lat_vld,
    output cofs_pkg::lat_t      lat_rd
);
    import cofs_pkg::*;

    lat_t                 lat_mem [NUM_PEERS];
    lat_t                 rd_reg;
    logic [NUM_PEERS-1:0] vld_reg;
    logic [NUM_PEERS-1:0] vld_next;

    // best width per peer, written when a run finishes
    always_ff @(posedge aclk) begin
        if (lat_wr.en) begin
            lat_mem[lat_wr.addr] <= lat_wr.data;
        end
    end

    // registered read with the same-cycle write passed through
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (lat_wr.en && (lat_wr.addr == rd_peer)) begin
                rd_reg <= lat_wr.data;
            end else begin
                rd_reg <= lat_mem[rd_peer];
            end
        end
    end

    // per-peer valid flags
    always_comb begin
        vld_next = vld_reg;
        if (lat_wr.en) begin
            vld_next[lat_wr.addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign lat_vld = vld_reg[chk_peer];
    assign lat_rd  = rd_reg;

endmodule

@@ rtl/cofs_engine.sv @@
module cofs_engine (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              proc,
    input  cofs_pkg::item_t   item,
    input  cofs_pkg::cfg_t    cfg,
    input  logic              lat_vld,
    input  cofs_pkg::lat_t    lat_rd,
    output cofs_pkg::result_t res,
    output cofs_pkg::lat_wr_t lat_wr
);
    import cofs_pkg::*;

    localparam int MUL_W = LAT_W + 4;
    localparam logic [PEER_BITS:0] PEER_LIMIT = (PEER_BITS + 1)'(NUM_PEERS);

    function automatic diff_t tdiff(input time_t a, input time_t b);
        return $signed({1'b0, a}) - $signed({1'b0, b});
    endfunction

    function automatic diff_t dmax(input diff_t a, input diff_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic diff_t dmin(input diff_t a, input diff_t b);
        return (a < b) ? a : b;
    endfunction

    logic [1:0] phase_reg, phase_next;
    time_t      older_reg, older_next;
    time_t      newer_reg, newer_next;
    time_t      saved_reg, saved_next;
    diff_t      low_reg, low_next;
    diff_t      high_reg, high_next;
    cnt_t       count_reg, count_next;

    diff_t             d_rt_lt, d_rt_old, d_rt_new, d_sv_old, rtt;
    diff_t             run_low, run_high, fin_low, fin_high;
    lat_t              fin_width, fin_sum, new_lat;
    diff_t             fin_ofs;
    logic signed [MUL_W-1:0] x_ext, y_ext, x10, y11;
    logic              run_stamp, early, peer_ok;
    cnt_t              cnt_inc;
    logic              fin;
    logic [1:0]        fin_act;
    cnt_t              fin_cnt;

    // bound candidates from this event
    assign d_rt_lt  = tdiff(item.remote_time, item.capture_time);
    assign d_rt_old = tdiff(item.remote_time, older_reg);
    assign d_rt_new = tdiff(item.remote_time, newer_reg);
    assign d_sv_old = tdiff(saved_reg, older_reg);
    assign rtt      = tdiff(item.capture_time, newer_reg);
    assign run_low  = dmax(low_reg, d_rt_lt);
    assign run_high = dmin(high_reg, d_rt_new);

    assign run_stamp = (item.req_type == REQ_STAMP) && (phase_reg == PH_RUN);
    assign fin_low   = run_stamp ? run_low : low_reg;
    assign fin_high  = run_stamp ? run_high : high_reg;

    // width, floor midpoint and new per-peer minimum
    assign fin_width = {fin_high[DIFF_W-1], fin_high} - {fin_low[DIFF_W-1], fin_low};
    assign fin_sum   = {fin_high[DIFF_W-1], fin_high} + {fin_low[DIFF_W-1], fin_low};
    assign fin_ofs   = $signed(fin_sum[LAT_W-1:1]);
    assign new_lat   = (lat_vld && (lat_rd < fin_width)) ? lat_rd : fin_width;

    // early stop: 10*rtt < 11*best with a valid non-negative best, once the count reaches min_exchanges
    assign x_ext = $signed({{(MUL_W - DIFF_W){rtt[DIFF_W-1]}}, rtt});
    assign y_ext = $signed({{(MUL_W - LAT_W){lat_rd[LAT_W-1]}}, lat_rd});
    assign x10   = (x_ext <<< 3) + (x_ext <<< 1);
    assign y11   = (y_ext <<< 3) + (y_ext <<< 1) + y_ext;
    assign early = lat_vld && !lat_rd[LAT_W-1] &&
                   (count_reg >= cfg.min_exchanges) && (x10 < y11);

    // saturating exchange count
    assign cnt_inc = (count_reg == '1) ? count_reg : count_reg + CNT_W'(1);
    assign peer_ok = {1'b0, item.peer} < PEER_LIMIT;

    // event handling per role and phase
    always_comb begin
        phase_next = phase_reg;
        older_next = older_reg;
        newer_next = newer_reg;
        saved_next = saved_reg;
        low_next   = low_reg;
        high_next  = high_reg;
        count_next = count_reg;
        res        = '0;
        res.action = ACT_IGN;
        lat_wr     = '0;
        lat_wr.addr = item.peer[PEER_IDX_W-1:0];
        lat_wr.data = new_lat;
        fin        = 1'b0;
        fin_act    = ACT_DONE;
        fin_cnt    = count_reg;
        if (proc && peer_ok) begin
            if (cfg.role == ROLE_INIT) begin
                if ((item.req_type == REQ_START) && (phase_reg == PH_IDLE)) begin
                    older_next    = item.capture_time;
                    count_next    = '0;
                    phase_next    = PH_FIRST;
                    res.action    = ACT_SEND;
                    res.send_time = item.capture_time;
                end else if ((item.req_type == REQ_STAMP) && (phase_reg == PH_FIRST)) begin
                    newer_next    = item.capture_time;
                    low_next      = d_rt_lt;
                    high_next     = d_rt_old;
                    count_next    = CNT_W'(1);
                    phase_next    = PH_RUN;
                    res.action    = ACT_SEND;
                    res.send_time = item.capture_time;
                    res.exchanges = CNT_W'(1);
                end else if (run_stamp) begin
                    older_next = newer_reg;
                    newer_next = item.capture_time;
                    low_next   = run_low;
                    high_next  = run_high;
                    if (early) begin
                        fin     = 1'b1;
                        fin_act = ACT_STOP;
                    end else begin
                        count_next = cnt_inc;
                        if (cnt_inc == cfg.max_exchanges) begin
                            fin     = 1'b1;
                            fin_act = ACT_STOP;
                            fin_cnt = cnt_inc;
                        end else begin
                            res.action    = ACT_SEND;
                            res.send_time = item.capture_time;
                            res.exchanges = cnt_inc;
                        end
                    end
                end else if ((item.req_type == REQ_STOP) && (phase_reg == PH_RUN)) begin
                    fin = 1'b1;
                end
            end else begin
                if ((item.req_type == REQ_STAMP) && (phase_reg == PH_IDLE)) begin
                    saved_next    = item.remote_time;
                    older_next    = item.capture_time;
                    count_next    = '0;
                    phase_next    = PH_FIRST;
                    res.action    = ACT_SEND;
                    res.send_time = item.capture_time;
                end else if ((item.req_type == REQ_STAMP) && (phase_reg == PH_FIRST)) begin
                    newer_next    = item.capture_time;
                    low_next      = dmax(d_sv_old, d_rt_lt);
                    high_next     = d_rt_old;
                    count_next    = CNT_W'(1);
                    phase_next    = PH_RUN;
                    res.action    = ACT_SEND;
                    res.send_time = item.capture_time;
                    res.exchanges = CNT_W'(1);
                end else if (run_stamp) begin
                    saved_next = item.remote_time;
                    older_next = newer_reg;
                    newer_next = item.capture_time;
                    low_next   = run_low;
                    high_next  = run_high;
                    if (early) begin
                        fin     = 1'b1;
                        fin_act = ACT_STOP;
                    end else begin
                        count_next    = cnt_inc;
                        res.action    = ACT_SEND;
                        res.send_time = item.capture_time;
                        res.exchanges = cnt_inc;
                    end
                end else if ((item.req_type == REQ_STOP) && (phase_reg == PH_RUN)) begin
                    older_next = newer_reg;
                    newer_next = item.capture_time;
                    fin        = 1'b1;
                end
            end
            // end of run: report estimate and keep the best width
            if (fin) begin
                phase_next        = PH_IDLE;
                res.action        = fin_act;
                res.send_time     = '0;
                res.offset        = fin_ofs;
                res.latency_bound = new_lat;
                res.exchanges     = fin_cnt;
                lat_wr.en         = 1'b1;
            end
        end
    end

    // run state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            older_reg <= '0;
            newer_reg <= '0;
            saved_reg <= '0;
            low_reg   <= '0;
            high_reg  <= '0;
            count_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            older_reg <= older_next;
            newer_reg <= newer_next;
            saved_reg <= saved_next;
            low_reg   <= low_next;
            high_reg  <= high_next;
            count_reg <= count_next;
        end
    end

endmodule

@@ rtl/pingpong_clock_offset_estimator.sv @@
// channel   direction  handshake            payload
// s_        in         s_tvalid/s_tready    tuser: req_type; tdata: peer, capture_time,
//                                           remote_time
// m_        out        m_tvalid/m_tready    tuser: action; tdata: send_time, offset,
//                                           latency_bound, exchanges
// cfg_      in         cfg_valid/cfg_ready  cfg_index: register, cfg_data: value
//
// one transaction per cycle sustained while m_tready is high; a request
// transaction is held in the input register and its result in the result
// register, which drives the result transaction
// the per-peer latency memory is read when a request is taken and written when
// its run finishes; the same-cycle write is passed through to the read
// reset clears run state and per-peer valid flags and sets config registers to defaults
// a stalled result holds the input register; cfg_ready is always high
module pingpong_clock_offset_estimator (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [cofs_pkg::S_TDATA_W-1:0]   s_tdata,   // peer, capture_time, remote_time
    input  logic [1:0]                       s_tuser,   // req_type
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [cofs_pkg::M_TDATA_W-1:0]   m_tdata,   // send_time, offset, latency_bound,
                                                        // exchanges
    output logic [1:0]                       m_tuser,   // action
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [cofs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cofs_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import cofs_pkg::*;

    cfg_t    cfg_reg, cfg_next;
    item_t   s_item;
    item_t   in_item_reg, in_item_next;
    logic    in_vld_reg, in_vld_next;
    result_t out_res_reg, out_res_next;
    logic    out_vld_reg, out_vld_next;
    result_t res;
    lat_wr_t lat_wr;
    lat_t    lat_rd;
    logic    lat_vld;
    logic    proc;
    logic    accept;

    // configuration writes
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_ROLE: cfg_next.role          = cfg_data[0];
                CFG_MIN:  cfg_next.min_exchanges = cfg_data;
                CFG_MAX:  cfg_next.max_exchanges = cfg_data;
                default:  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.role          <= ROLE_INIT;
            cfg_reg.min_exchanges <= CNT_W'(1);
            cfg_reg.max_exchanges <= CNT_W'(100);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // unpack the request transaction
    assign s_item.req_type     = s_tuser;
    assign s_item.peer         = s_tdata[PEER_BITS-1:0];
    assign s_item.capture_time = s_tdata[PEER_BITS +: TIME_BITS];
    assign s_item.remote_time  = s_tdata[PEER_BITS + TIME_BITS +: TIME_BITS];

    // pipeline control
    assign proc     = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || proc;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        in_vld_next  = in_vld_reg;
        in_item_next = in_item_reg;
        out_vld_next = out_vld_reg;
        out_res_next = out_res_reg;
        if (accept) begin
            in_vld_next  = 1'b1;
            in_item_next = s_item;
        end else if (proc) begin
            in_vld_next = 1'b0;
        end
        if (proc) begin
            out_vld_next = 1'b1;
            out_res_next = res;
        end else if (m_tready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_item_reg <= in_item_next;
        out_res_reg <= out_res_next;
    end

    cofs_lat_store u_lat_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (accept),
        .rd_peer  (s_item.peer[PEER_IDX_W-1:0]),
        .chk_peer (in_item_reg.peer[PEER_IDX_W-1:0]),
        .lat_wr   (lat_wr),
        .lat_vld  (lat_vld),
        .lat_rd   (lat_rd)
    );

    cofs_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .proc    (proc),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .lat_vld (lat_vld),
        .lat_rd  (lat_rd),
        .res     (res),
        .lat_wr  (lat_wr)
    );

    // result packing
    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_res_reg.action;
    assign m_tdata  = M_TDATA_W'({out_res_reg.exchanges, out_res_reg.latency_bound,
                                  out_res_reg.offset, out_res_reg.send_time});

    // a processed request always leaves a result
    assert property (@(posedge aclk) disable iff (!aresetn) proc |=> m_tvalid)
        else $error("processed request produced no result");

    // ignored requests carry an all-zero payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == ACT_IGN)) |-> (m_tdata == '0))
        else $error("ignored result with nonzero payload");

    // send results carry no estimate
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == ACT_SEND)) |->
        ((out_res_reg.offset == '0) && (out_res_reg.latency_bound == '0)))
        else $error("send result with estimate fields set");

endmodule
